// ===== rtl/core/rse_pkg.sv =====
package rse_pkg;

  localparam int SYM_BITS    = 4;
  localparam int PARITY_SYMS = 6;
  localparam int DATA_SYMS   = 9;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // x^4 + x + 1
  localparam logic [SYM_BITS:0] FIELD_POLY = 5'h13;

  typedef logic [SYM_BITS-1:0]                  sym_t;
  typedef logic [PARITY_SYMS-1:0][SYM_BITS-1:0] par_t;
  typedef logic [PARITY_SYMS:0][SYM_BITS-1:0]   gen_t;
  typedef logic [3:0]                           count_t;
  typedef logic [2:0]                           phase_t;

  // Output phase of one queued request: data echo, then parity 1..6
  localparam phase_t PH_DATA = 3'd0;
  localparam phase_t PH_LAST = 3'd6;

  // One queued request: the data symbol, whether it closes the codeword,
  // and the remainder snapshot taken after it was shifted in
  typedef struct packed {
    sym_t  sym;
    logic  last;
    par_t  parity;
  } entry_t;

  // GF(16) multiply, shift-and-add with reduction
  function automatic sym_t gf_mul(sym_t a, sym_t b);
    logic [SYM_BITS:0] acc_a;
    sym_t              r;
    acc_a = {1'b0, a};
    r     = '0;
    for (int s = 0; s < SYM_BITS; s++) begin
      if (b[s]) r ^= acc_a[SYM_BITS-1:0];
      acc_a = {acc_a[SYM_BITS-1:0], 1'b0};
      if (acc_a[SYM_BITS]) acc_a ^= FIELD_POLY;
    end
    return r;
  endfunction

  // Generator g(x) = (x + a^1)...(x + a^6); entry d is the x^d coefficient
  function automatic gen_t build_gen();
    gen_t g;
    sym_t root;
    g    = '0;
    g[0] = sym_t'(1);
    root = sym_t'(1);
    for (int r = 1; r <= PARITY_SYMS; r++) begin
      root = gf_mul(root, sym_t'(2));
      for (int d = r; d > 0; d--) begin
        g[d] = g[d-1] ^ gf_mul(g[d], root);
      end
      g[0] = gf_mul(g[0], root);
    end
    return g;
  endfunction

  localparam gen_t GEN = build_gen();

endpackage

// ===== rtl/core/rs_15_9_systematic_encoder.sv =====
// Systematic RS(15,9) encoder over GF(16) (field x^4+x+1, roots alpha^1..alpha^6).
// Each accepted data symbol is echoed as a data result; after symbols_per_block
// symbols (0 acts as 1, above 9 as 9) the six parity symbols follow, highest
// degree first, the last with block_end. The input side takes one symbol per
// cycle while its two-entry request queue has room; the output register gives
// one result per cycle while out_stall is low, so a full codeword of 9 symbols
// gives 15 results and the sustained input rate is set by the output port. An
// accepted data symbol is written into the request queue and moves into the
// output register when the output side is free.
// symbols_per_block may be written at any time and takes effect from the next
// accepted symbol.
module rs_15_9_systematic_encoder (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rse_pkg::sym_t data_symbol,
  output logic          out_valid,
  input  logic          out_stall,
  output rse_pkg::sym_t code_symbol,
  output logic          is_parity,
  output logic          block_end,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [3:0]    symbols_per_block
);
  import rse_pkg::*;

  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_nonempty;
  entry_t push_entry;
  entry_t pop_entry;

  // Accept, shift the remainder and tag codeword ends
  rse_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .data_symbol       (data_symbol),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .symbols_per_block (symbols_per_block),
    .q_full            (q_full),
    .push              (push),
    .push_entry        (push_entry)
  );

  // Decouple the input side from the output side
  rse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .full       (q_full),
    .nonempty   (q_nonempty)
  );

  // Serialize each request into its results
  rse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_nonempty),
    .q_entry     (pop_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_symbol (code_symbol),
    .is_parity   (is_parity),
    .block_end   (block_end)
  );

`ifndef NO_ASSERTIONS
  a_end_is_parity: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_end |-> is_parity)
    else $error("block_end on a data result");

  a_parity_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && is_parity && !block_end |=> out_valid && is_parity)
    else $error("parity run broken before its last symbol");

  a_after_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && block_end |=> !(out_valid && is_parity))
    else $error("parity result right after a codeword end");

  a_queue_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_nonempty && !(push && q_full))
    else $error("request queue under- or overrun");
`endif

endmodule

// ===== rtl/core/rse_front.sv =====
module rse_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rse_pkg::sym_t   data_symbol,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [3:0]      symbols_per_block,
  input  logic            q_full,
  output logic            push,
  output rse_pkg::entry_t push_entry
);
  import rse_pkg::*;

  localparam count_t MAX_LEN = count_t'(DATA_SYMS);

  count_t block_len;
  count_t count;
  count_t count_next;
  count_t limit;
  par_t   stages;
  par_t   stages_next;
  sym_t   fb;
  logic   last;

  // Configuration is always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_len <= MAX_LEN;
    end else if (cfg_valid && cfg_ready) begin
      block_len <= symbols_per_block;
    end
  end

  // Clamp the block length into 1..DATA_SYMS
  always_comb begin
    if (block_len == '0) begin
      limit = count_t'(1);
    end else if (block_len > MAX_LEN) begin
      limit = MAX_LEN;
    end else begin
      limit = block_len;
    end
  end

  // Divide by g(x): one LFSR shift per data symbol
  assign fb = data_symbol ^ stages[PARITY_SYMS-1];

  always_comb begin
    stages_next[0] = gf_mul(GEN[0], fb);
    for (int d = 1; d < PARITY_SYMS; d++) begin
      stages_next[d] = stages[d-1] ^ gf_mul(GEN[d], fb);
    end
  end

  assign count_next = count + count_t'(1);
  assign last       = (count_next >= limit);

  // Hold off the source while the queue is full
  assign in_stall = q_full;
  assign push     = in_valid && !in_stall;

  assign push_entry.sym    = data_symbol;
  assign push_entry.last   = last;
  assign push_entry.parity = stages_next;

  // Advance the remainder; drop it at the end of each codeword
  always_ff @(posedge clk) begin
    if (rst) begin
      stages <= '0;
      count  <= '0;
    end else if (push) begin
      stages <= last ? '0 : stages_next;
      count  <= last ? '0 : count_next;
    end
  end

endmodule

// ===== rtl/core/rse_queue.sv =====
module rse_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rse_pkg::entry_t push_entry,
  input  logic            pop,
  output rse_pkg::entry_t pop_entry,
  output logic            full,
  output logic            nonempty
);
  import rse_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   level;

  assign full      = (level == (QPTR_W+1)'(QUEUE_DEPTH));
  assign nonempty  = (level != '0);
  assign pop_entry = slots[rd_ptr];

  // Store a request at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) begin
        level <= level + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        level <= level - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/core/rse_back.sv =====
module rse_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  rse_pkg::entry_t q_entry,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output rse_pkg::sym_t   code_symbol,
  output logic            is_parity,
  output logic            block_end
);
  import rse_pkg::*;

  entry_t cur;
  logic   cur_valid;
  phase_t phase;
  phase_t par_sel;
  logic   fire;
  logic   done;

  assign fire = cur_valid && !out_stall;
  assign done = ((phase == PH_DATA) && !cur.last) || (phase == PH_LAST);
  assign pop  = q_valid && (!cur_valid || (fire && done));

  // Step through the echo and the parity run of the held request
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= PH_DATA;
    end else if (pop) begin
      cur_valid <= 1'b1;
      phase     <= PH_DATA;
    end else if (fire) begin
      if (done) begin
        cur_valid <= 1'b0;
      end else begin
        phase <= phase + phase_t'(1);
      end
    end
  end

  // Load the next request
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_entry;
    end
  end

  // Parity goes out highest degree first
  assign par_sel     = PH_LAST - phase;
  assign out_valid   = cur_valid;
  assign code_symbol = (phase == PH_DATA) ? cur.sym : cur.parity[par_sel];
  assign is_parity   = (phase != PH_DATA);
  assign block_end   = (phase == PH_LAST);

endmodule

// ===== test/tb_rs_15_9_systematic_encoder.sv =====
module tb_rs_15_9_systematic_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import rse_pkg::*;

  localparam int DIR_ROWS       = 25;
  localparam int RANDOM_ITEMS   = 75;
  localparam int QUIET_ITEMS    = 55;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic {ROW_CFG, ROW_SYM} row_kind_t;

  // One directed row: a length write or a data symbol, optionally with
  // its codeword typed in (zero data gives zero parity)
  typedef struct packed {
    row_kind_t  kind;
    logic       typed;
    logic       closes;
    logic [3:0] value;
  } stim_row_t;

  typedef struct packed {
    sym_t sym;
    logic par;
    logic last;
  } code_res_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  sym_t       data_symbol;
  logic       out_valid;
  logic       out_stall;
  sym_t       code_symbol;
  logic       is_parity;
  logic       block_end;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] symbols_per_block;

  // Encoder model state
  sym_t       gen_taps [0:PARITY_SYMS];
  sym_t       lfsr_pred [0:PARITY_SYMS-1];
  logic [3:0] taken_pred;
  logic [3:0] len_reg;

  code_res_t  step_codes [$];
  code_res_t  pending_codes [$];

  int  errors;
  int  items_sent;
  int  idle_cycles;
  bit  quiet;
  bit  gaps_on;
  bit  hold_req;

  rs_15_9_systematic_encoder dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .data_symbol       (data_symbol),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .code_symbol       (code_symbol),
    .is_parity         (is_parity),
    .block_end         (block_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .symbols_per_block (symbols_per_block)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // GF(16) product, x^4 = x + 1
  function automatic sym_t gf16_times(sym_t a, sym_t b);
    sym_t p;
    sym_t x;
    p = '0;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p ^= x;
      x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
    end
    return p;
  endfunction

  // Directed stimulus table
  function automatic stim_row_t dir_row(int i);
    stim_row_t r;
    case (i)
      0, 1, 2, 3, 4, 5, 6, 7: r = {ROW_SYM, 1'b1, 1'b0, 4'h0};
      8:  r = {ROW_SYM, 1'b1, 1'b1, 4'h0};
      9:  r = {ROW_CFG, 1'b0, 1'b0, 4'd1};
      10: r = {ROW_SYM, 1'b0, 1'b0, 4'hf};
      11: r = {ROW_SYM, 1'b0, 1'b0, 4'h1};
      12: r = {ROW_CFG, 1'b0, 1'b0, 4'd0};
      13: r = {ROW_SYM, 1'b1, 1'b1, 4'h0};
      14: r = {ROW_SYM, 1'b0, 1'b0, 4'h9};
      15: r = {ROW_CFG, 1'b0, 1'b0, 4'd15};
      16: r = {ROW_SYM, 1'b0, 1'b0, 4'h8};
      17: r = {ROW_SYM, 1'b0, 1'b0, 4'h4};
      18: r = {ROW_SYM, 1'b0, 1'b0, 4'h2};
      19: r = {ROW_CFG, 1'b0, 1'b0, 4'd2};
      20: r = {ROW_SYM, 1'b0, 1'b0, 4'h7};
      21: r = {ROW_CFG, 1'b0, 1'b0, 4'd10};
      22: r = {ROW_SYM, 1'b0, 1'b0, 4'h3};
      23: r = {ROW_SYM, 1'b0, 1'b0, 4'hc};
      default: r = {ROW_CFG, 1'b0, 1'b0, 4'd9};
    endcase
    return r;
  endfunction

  // Shift one symbol through the remainder and collect the codeword results
  task automatic predict_encode(input sym_t s);
    sym_t       fb;
    logic [3:0] lim;
    step_codes.delete();
    fb = s ^ lfsr_pred[PARITY_SYMS-1];
    for (int d = PARITY_SYMS - 1; d > 0; d--)
      lfsr_pred[d] = lfsr_pred[d-1] ^ gf16_times(gen_taps[d], fb);
    lfsr_pred[0] = gf16_times(gen_taps[0], fb);
    step_codes.push_back({s, 1'b0, 1'b0});
    lim = len_reg;
    if (lim < 1) lim = 1;
    if (lim > DATA_SYMS) lim = DATA_SYMS;
    taken_pred = taken_pred + 4'd1;
    if (taken_pred >= lim) begin
      for (int d = PARITY_SYMS - 1; d >= 0; d--)
        step_codes.push_back({lfsr_pred[d], 1'b1, d == 0});
      for (int d = 0; d < PARITY_SYMS; d++) lfsr_pred[d] = '0;
      taken_pred = '0;
    end
  endtask

  // Offer one symbol, hold it until taken, then record its results
  task automatic send_symbol(input sym_t s, input logic typed, input logic closes);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_symbol <= s;
    do @(posedge clk); while (in_stall);
    items_sent++;
    predict_encode(s);
    if (typed) begin
      step_codes.delete();
      step_codes.push_back({s, 1'b0, 1'b0});
      if (closes)
        for (int d = PARITY_SYMS - 1; d >= 0; d--)
          step_codes.push_back({sym_t'(0), 1'b1, d == 0});
    end
    foreach (step_codes[k]) pending_codes.push_back(step_codes[k]);
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_codes.size() != 0);
  endtask

  // Write the block length while the encoder is idle
  task automatic write_length(input logic [3:0] v);
    settle();
    cfg_valid         <= 1'b1;
    symbols_per_block <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    len_reg = v;
  endtask

  // Main sequence
  initial begin
    stim_row_t  row;
    sym_t       root;
    logic [3:0] len;
    int         nsym;
    int         phase;
    int         pick;

    errors     = 0;
    items_sent = 0;
    quiet      = 1'b0;
    gaps_on    = 1'b1;
    hold_req   = 1'b0;

    // build g(x) with roots alpha^1..alpha^6
    for (int d = 0; d <= PARITY_SYMS; d++) gen_taps[d] = '0;
    gen_taps[0] = 4'h1;
    root = 4'h1;
    for (int r = 1; r <= PARITY_SYMS; r++) begin
      root = gf16_times(root, 4'h2);
      for (int d = r; d > 0; d--)
        gen_taps[d] = gen_taps[d-1] ^ gf16_times(gen_taps[d], root);
      gen_taps[0] = gf16_times(gen_taps[0], root);
    end
    for (int d = 0; d < PARITY_SYMS; d++) lfsr_pred[d] = '0;
    taken_pred = '0;
    len_reg    = 4'd9;

    rst               <= 1'b1;
    in_valid          <= 1'b0;
    data_symbol       <= '0;
    cfg_valid         <= 1'b0;
    symbols_per_block <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_row(i);
      if (row.kind == ROW_CFG) write_length(row.value);
      else send_symbol(row.value, row.typed, row.closes);
    end

    // random phases: full length first, then length one, then the long hold
    phase = 0;
    while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 7);
      if (phase == 0) len = 4'd9;
      else if (phase == 1) len = 4'd1;
      else if (pick == 0) begin
        pick = $urandom_range(0, 6);
        len = (pick == 0) ? 4'd0 : 4'(9 + pick);
      end else len = 4'($urandom_range(1, 9));
      write_length(len);
      if (phase == 2) begin
        nsym     = 18;
        gaps_on  = 1'b0;
        hold_req = 1'b1;
      end else begin
        nsym    = $urandom_range(1, 18);
        gaps_on = !quiet && ($urandom_range(0, 4) != 0);
      end
      repeat (nsym) send_symbol(4'($urandom_range(0, 15)), 1'b0, 1'b0);
      phase++;
      if (items_sent >= DIR_ROWS + QUIET_ITEMS) quiet = 1'b1;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_codes.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Receiver: random stall bursts, one long hold on request
  initial begin
    int n;
    out_stall <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        n = HOLD_CYCLES;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 5);
      end else begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 4);
      end
      repeat (n) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    code_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_codes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got sym=%h par=%b end=%b",
                 $realtime, code_symbol, is_parity, block_end);
      end else begin
        want = pending_codes.pop_front();
        if (want.sym !== code_symbol || want.par !== is_parity ||
            want.last !== block_end) begin
          errors++;
          $display("%0t: mismatch: expected sym=%h par=%b end=%b, got sym=%h par=%b end=%b",
                   $realtime, want.sym, want.par, want.last,
                   code_symbol, is_parity, block_end);
        end
      end
    end
  end

  // Watchdog: end the run when no request moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
